// ===== hdl/saxk_pkg.sv =====
package saxk_pkg;

	localparam int VALUE_W = 16;
	localparam int BP_INDEX_W = 8;
	localparam int KEY_W = 64;
	localparam int SERIES_NUM_W = 32;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_INDEX_W = 2;
	localparam int BP_DEPTH = 255;
	localparam int COUNT_W = 8;

	localparam int DEF_MAX_SYMBOL_BITS = 8;
	localparam int DEF_MAX_SEGMENTS = 8;
	localparam int DEF_MAX_SERIES_LENGTH = 4096;

	localparam logic [CFG_INDEX_W-1:0] REG_SERIES_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_LENGTH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_COUNT = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_BITS = 2'd3;

	localparam logic [CFG_DATA_W-1:0] RST_SERIES_LENGTH = 13'd256;
	localparam logic [CFG_DATA_W-1:0] RST_SEGMENT_LENGTH = 13'd32;
	localparam logic [3:0] RST_SEGMENT_COUNT = 4'd8;
	localparam logic [3:0] RST_SYMBOL_BITS = 4'd8;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

endpackage

// ===== hdl/sax_interleaved_key_encoder.sv =====
// Symbolic key encoder for signed Q4.12 series. Breakpoint loads (op 0) and samples (op 1)
// arrive as input beats; a sample that does not close a segment starts no scan.
// A sample that closes a segment starts a scan of the breakpoint memory through one shared
// multiplier and comparator, one breakpoint per cycle; no further beat is taken until
// the scan is finished. The last sample of a series then shifts the segment_count *
// symbol_bits bits of the interleaved key out of the symbol store, one bit a cycle,
// and loads the output register. The output beat carries the key and the series number;
// the block accepts further beats while it waits to be taken, but a following key is
// held until the output register is free. Breakpoints must be written before a scan
// reads them.
module sax_interleaved_key_encoder
	import saxk_pkg::*;
#(
	parameter int MAX_SYMBOL_BITS = DEF_MAX_SYMBOL_BITS,
	parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
	parameter int MAX_SERIES_LENGTH = DEF_MAX_SERIES_LENGTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      op,
	input  logic [BP_INDEX_W-1:0]     bp_index,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [KEY_W-1:0]          key,
	output logic [SERIES_NUM_W-1:0]   series_number
);

	localparam int LEN_W = $clog2(MAX_SERIES_LENGTH + 1);
	localparam int POS_W = $clog2(MAX_SERIES_LENGTH);
	localparam int SUM_W = VALUE_W + POS_W;
	localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
	localparam int SEGI_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int SB_W = $clog2(MAX_SYMBOL_BITS + 1);
	localparam int BIT_W = (MAX_SYMBOL_BITS > 1) ? $clog2(MAX_SYMBOL_BITS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_KEY = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [CFG_DATA_W-1:0] series_len_q;
	logic [CFG_DATA_W-1:0] segment_len_q;
	logic [3:0]            segment_cnt_q;
	logic [3:0]            symbol_bits_q;

	logic [LEN_W-1:0]  slen;
	logic [LEN_W-1:0]  seglen;
	logic [SEG_W-1:0]  segs;
	logic [SB_W-1:0]   sbits;
	logic [COUNT_W-1:0] bp_last;

	logic [1:0]            state_q;
	logic                  end_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [POS_W-1:0]      sample_pos_q;
	logic [POS_W-1:0]      seg_pos_q;
	logic [SEG_W-1:0]      seg_idx_q;
	logic [MAX_SYMBOL_BITS-1:0] sym_q [MAX_SEGMENTS];
	logic [SERIES_NUM_W-1:0] series_cnt_q;

	logic [COUNT_W-1:0] scan_addr_q;
	logic               issue_done_q;
	logic [COUNT_W-1:0] count_q;
	logic               rv_s1;
	logic               rv_s2;
	logic signed [VALUE_W-1:0] bp_s1;
	logic signed [SUM_W-1:0]   prod_s2;
	logic signed [SUM_W-1:0]   mul_a;
	logic signed [SUM_W-1:0]   mul_b;

	logic [BIT_W-1:0]  bit_q;
	logic [SEGI_W-1:0] col_q;
	logic [KEY_W-1:0]  key_q;

	logic [VALUE_W-1:0] bp_mem [BP_DEPTH];

	logic                    in_beat;
	logic                    sample_beat;
	logic                    seg_active;
	logic signed [SUM_W-1:0] next_sum;
	logic                    seg_end;
	logic                    series_end;
	logic                    issue;
	logic                    scan_finish;
	logic                    out_free;

	always_comb begin
		if (series_len_q == '0) begin
			slen = LEN_W'(1);
		end else if (32'(series_len_q) > 32'(MAX_SERIES_LENGTH)) begin
			slen = LEN_W'(MAX_SERIES_LENGTH);
		end else begin
			slen = LEN_W'(series_len_q);
		end
		if (segment_len_q == '0) begin
			seglen = LEN_W'(1);
		end else if (32'(segment_len_q) > 32'(MAX_SERIES_LENGTH)) begin
			seglen = LEN_W'(MAX_SERIES_LENGTH);
		end else begin
			seglen = LEN_W'(segment_len_q);
		end
		if (segment_cnt_q == '0) begin
			segs = SEG_W'(1);
		end else if (32'(segment_cnt_q) > 32'(MAX_SEGMENTS)) begin
			segs = SEG_W'(MAX_SEGMENTS);
		end else begin
			segs = SEG_W'(segment_cnt_q);
		end
		if (symbol_bits_q == '0) begin
			sbits = SB_W'(1);
		end else if (32'(symbol_bits_q) > 32'(MAX_SYMBOL_BITS)) begin
			sbits = SB_W'(MAX_SYMBOL_BITS);
		end else begin
			sbits = SB_W'(symbol_bits_q);
		end
		bp_last = COUNT_W'((9'd1 << sbits) - 9'd2);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign in_beat = in_valid && in_ready;
	assign sample_beat = in_beat && (op == OP_SAMPLE);
	assign seg_active = (seg_idx_q < segs);
	assign next_sum = sum_q + SUM_W'(value);
	assign seg_end = (LEN_W'(seg_pos_q) + LEN_W'(1)) >= seglen;
	assign series_end = (LEN_W'(sample_pos_q) + LEN_W'(1)) >= slen;
	assign issue = (state_q == ST_SCAN) && !issue_done_q;
	assign scan_finish = (state_q == ST_SCAN) && issue_done_q && !rv_s1 && !rv_s2;
	assign out_free = !out_valid || out_ready;
	assign mul_a = SUM_W'(bp_s1);
	assign mul_b = $signed(SUM_W'(seglen));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_len_q <= RST_SERIES_LENGTH;
			segment_len_q <= RST_SEGMENT_LENGTH;
			segment_cnt_q <= RST_SEGMENT_COUNT;
			symbol_bits_q <= RST_SYMBOL_BITS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SERIES_LENGTH: series_len_q <= cfg_data;
				REG_SEGMENT_LENGTH: segment_len_q <= cfg_data;
				REG_SEGMENT_COUNT: segment_cnt_q <= cfg_data[3:0];
				REG_SYMBOL_BITS: symbol_bits_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat && (op == OP_LOAD) && (bp_index != BP_INDEX_W'(BP_DEPTH))) begin
			bp_mem[bp_index] <= value;
		end
		if (issue) begin
			bp_s1 <= bp_mem[scan_addr_q];
		end
		prod_s2 <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			end_q <= 1'b0;
			sum_q <= '0;
			sample_pos_q <= '0;
			seg_pos_q <= '0;
			seg_idx_q <= '0;
			for (int i = 0; i < MAX_SEGMENTS; i++) begin
				sym_q[i] <= '0;
			end
			series_cnt_q <= '0;
			scan_addr_q <= '0;
			issue_done_q <= 1'b0;
			count_q <= '0;
			rv_s1 <= 1'b0;
			rv_s2 <= 1'b0;
			bit_q <= '0;
			col_q <= '0;
			key_q <= '0;
			out_valid <= 1'b0;
			key <= '0;
			series_number <= '0;
		end else begin
			rv_s1 <= issue;
			rv_s2 <= rv_s1;
			if (out_valid && out_ready && (state_q != ST_EMIT)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample_beat) begin
						end_q <= series_end;
						if (!series_end) begin
							sample_pos_q <= sample_pos_q + POS_W'(1);
						end
						if (seg_active && seg_end) begin
							sum_q <= next_sum;
							scan_addr_q <= '0;
							issue_done_q <= 1'b0;
							count_q <= '0;
							state_q <= ST_SCAN;
						end else begin
							if (seg_active) begin
								sum_q <= next_sum;
								seg_pos_q <= seg_pos_q + POS_W'(1);
							end
							if (series_end) begin
								bit_q <= BIT_W'(sbits - SB_W'(1));
								col_q <= '0;
								key_q <= '0;
								state_q <= ST_KEY;
							end
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						if (scan_addr_q == bp_last) begin
							issue_done_q <= 1'b1;
						end else begin
							scan_addr_q <= scan_addr_q + COUNT_W'(1);
						end
					end
					if (rv_s2 && (prod_s2 < sum_q)) begin
						count_q <= count_q + COUNT_W'(1);
					end
					if (scan_finish) begin
						sym_q[seg_idx_q[SEGI_W-1:0]] <= count_q[MAX_SYMBOL_BITS-1:0];
						seg_idx_q <= seg_idx_q + SEG_W'(1);
						sum_q <= '0;
						seg_pos_q <= '0;
						if (end_q) begin
							bit_q <= BIT_W'(sbits - SB_W'(1));
							col_q <= '0;
							key_q <= '0;
							state_q <= ST_KEY;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_KEY: begin
					key_q <= {key_q[KEY_W-2:0], sym_q[col_q][bit_q]};
					if (SEG_W'(col_q) == segs - SEG_W'(1)) begin
						col_q <= '0;
						bit_q <= bit_q - BIT_W'(1);
						if (bit_q == '0) begin
							state_q <= ST_EMIT;
						end
					end else begin
						col_q <= col_q + SEGI_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						key <= key_q;
						series_number <= series_cnt_q;
						series_cnt_q <= series_cnt_q + SERIES_NUM_W'(1);
						sample_pos_q <= '0;
						seg_pos_q <= '0;
						seg_idx_q <= '0;
						sum_q <= '0;
						for (int i = 0; i < MAX_SEGMENTS; i++) begin
							sym_q[i] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/saxk_checker.sv =====
module saxk_checker
	import saxk_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [KEY_W-1:0]        key,
	input logic [SERIES_NUM_W-1:0] series_number
);

	logic [SERIES_NUM_W-1:0] expect_num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_num_q <= '0;
		end else if (out_valid && out_ready) begin
			expect_num_q <= expect_num_q + SERIES_NUM_W'(1);
		end
	end

	// A waiting output beat keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key) && $stable(series_number))
		else $error("output beat changed while stalled");

	// Series numbers count up by one per delivered beat, starting at zero.
	a_series_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> series_number == expect_num_q)
		else $error("series number out of sequence");

	// A new key is produced only while input beats are refused.
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("key produced while input was open");

	// Reset leaves no result pending.
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid after reset");

endmodule

bind sax_interleaved_key_encoder saxk_checker u_saxk_checker (.*);
